[rtl/core/rhws_pkg.sv]
`timescale 1ns / 1ps

package rhws_pkg;

    // Field widths
    localparam int MS_W    = 10;
    localparam int LED_W   = 6;
    localparam int CHAN_W  = 8;
    localparam int PHASE_W = 12;
    localparam int X_W     = 10;

    // Hue wheel geometry: six segments of 600 units
    localparam int SEG_LEN   = 600;
    localparam int WHEEL_LEN = 6 * SEG_LEN;
    localparam int FULL      = 255;

    // Largest LED count the index field can carry
    localparam int LED_MAX = 64;

    // floor(z / 5) == (z * DIV5_MUL) >> DIV5_SH for z below 16384
    localparam int DIV5_MUL = 13108;
    localparam int DIV5_SH  = 16;

    // Wheel segment, in hue order
    typedef enum logic [2:0] {
        SEG_RED_UP_G   = 3'd0,
        SEG_GRN_DN_R   = 3'd1,
        SEG_GRN_UP_B   = 3'd2,
        SEG_BLU_DN_G   = 3'd3,
        SEG_BLU_UP_R   = 3'd4,
        SEG_RED_DN_B   = 3'd5
    } t_seg;

endpackage

[rtl/core/rainbow_hue_wheel_strip_unit.sv]
`timescale 1ns / 1ps

// Rainbow hue wheel for an LED strip. Each input word is one animation tick
// carrying the elapsed milliseconds; the tick advances a hue phase kept modulo
// 3600 and the block then returns one RGB word per LED, LED 0 first, with
// o_last_led set on the word for LED LED_COUNT-1 (LED_COUNT is clamped to
// 1..64). The per-LED counter emits one LED per cycle while the output is
// not stalled, and the next tick is taken in the same cycle the last LED of
// the current one leaves the counter, so a steady stream of ticks gives one
// result word every cycle unless the output stalls. A tick's first result
// passes the counter, the segment stage and the color stage in that order.
// Output backpressure stalls the whole pipeline.
module rainbow_hue_wheel_strip_unit
    import rhws_pkg::*;
#(
    parameter int LED_COUNT = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // tick input
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [MS_W-1:0]     i_elapsed_ms,
    // color output
    output logic                o_valid,
    input  logic                i_ready,
    output logic [LED_W-1:0]    o_led_index,
    output logic [CHAN_W-1:0]   o_red,
    output logic [CHAN_W-1:0]   o_green,
    output logic [CHAN_W-1:0]   o_blue,
    output logic                o_last_led
);

    // LED count held to what the index field can carry
    localparam int LEDS     = (LED_COUNT < 1) ? 1 :
                              ((LED_COUNT > LED_MAX) ? LED_MAX : LED_COUNT);

    // Per-LED offset 1200*led/N, stepped by quotient and remainder
    localparam int OFF_SPAN = 2 * SEG_LEN;
    localparam int OFF_STEP = OFF_SPAN / LEDS;
    localparam int REM_STEP = OFF_SPAN % LEDS;
    localparam int OFF_W    = $clog2(OFF_SPAN);
    localparam int REM_W    = $clog2(LEDS) + 1;

    logic                 en;
    logic                 in_take;
    logic                 gen_last;

    // Tick / LED counter state
    logic                 r_busy;
    logic [PHASE_W-1:0]   r_phase;
    logic [LED_W-1:0]     r_led;
    logic [OFF_W-1:0]     r_off;
    logic [REM_W-1:0]     r_rem;

    logic [PHASE_W-1:0]   n_phase;
    logic [LED_W-1:0]     n_led;
    logic [OFF_W-1:0]     n_off;
    logic [REM_W-1:0]     n_rem;

    // Segment stage
    logic                 r_s1_valid;
    t_seg                 r_s1_seg;
    logic [X_W-1:0]       r_s1_x;
    logic [LED_W-1:0]     r_s1_led;
    logic                 r_s1_last;

    t_seg                 n_s1_seg;
    logic [X_W-1:0]       n_s1_x;

    // Color stage / output register
    logic                 r_o_valid;
    logic [LED_W-1:0]     r_o_led;
    logic [CHAN_W-1:0]    r_o_red;
    logic [CHAN_W-1:0]    r_o_green;
    logic [CHAN_W-1:0]    r_o_blue;
    logic                 r_o_last;

    logic [CHAN_W-1:0]    n_red;
    logic [CHAN_W-1:0]    n_green;
    logic [CHAN_W-1:0]    n_blue;

    // Pipeline moves when the output slot is free or being taken
    assign en       = !r_o_valid || i_ready;
    assign gen_last = (r_led == LED_W'(LEDS - 1));
    assign o_ready  = !r_busy || (gen_last && en);
    assign in_take  = i_valid && o_ready;

    // Phase advance: sum stays below two wheel turns
    logic [PHASE_W:0] phase_sum;
    always_comb begin
        phase_sum = {1'b0, r_phase} + (PHASE_W+1)'(i_elapsed_ms);
        if (phase_sum >= (PHASE_W+1)'(WHEEL_LEN)) begin
            n_phase = PHASE_W'(phase_sum - (PHASE_W+1)'(WHEEL_LEN));
        end else begin
            n_phase = phase_sum[PHASE_W-1:0];
        end
    end

    // Next LED offset and remainder
    logic [REM_W-1:0] rem_sum;
    always_comb begin
        rem_sum = r_rem + REM_W'(REM_STEP);
        n_led   = r_led + LED_W'(1);
        if (rem_sum >= REM_W'(LEDS)) begin
            n_rem = rem_sum - REM_W'(LEDS);
            n_off = r_off + OFF_W'(OFF_STEP) + OFF_W'(1);
        end else begin
            n_rem = rem_sum;
            n_off = r_off + OFF_W'(OFF_STEP);
        end
    end

    // Local phase, its segment and the offset inside it
    logic [PHASE_W:0]   local_sum;
    logic [PHASE_W-1:0] local_ph;
    logic [PHASE_W-1:0] seg_base;
    always_comb begin
        local_sum = {1'b0, r_phase} + (PHASE_W+1)'(r_off);
        if (local_sum >= (PHASE_W+1)'(WHEEL_LEN)) begin
            local_ph = PHASE_W'(local_sum - (PHASE_W+1)'(WHEEL_LEN));
        end else begin
            local_ph = local_sum[PHASE_W-1:0];
        end
        if (local_ph >= PHASE_W'(5 * SEG_LEN)) begin
            n_s1_seg = SEG_RED_DN_B;
            seg_base = PHASE_W'(5 * SEG_LEN);
        end else if (local_ph >= PHASE_W'(4 * SEG_LEN)) begin
            n_s1_seg = SEG_BLU_UP_R;
            seg_base = PHASE_W'(4 * SEG_LEN);
        end else if (local_ph >= PHASE_W'(3 * SEG_LEN)) begin
            n_s1_seg = SEG_BLU_DN_G;
            seg_base = PHASE_W'(3 * SEG_LEN);
        end else if (local_ph >= PHASE_W'(2 * SEG_LEN)) begin
            n_s1_seg = SEG_GRN_UP_B;
            seg_base = PHASE_W'(2 * SEG_LEN);
        end else if (local_ph >= PHASE_W'(SEG_LEN)) begin
            n_s1_seg = SEG_GRN_DN_R;
            seg_base = PHASE_W'(SEG_LEN);
        end else begin
            n_s1_seg = SEG_RED_UP_G;
            seg_base = '0;
        end
        n_s1_x = X_W'(local_ph - seg_base);
    end

    // Ramp x*255/600 = floor(floor(x*17/8) / 5)
    logic [13:0]       x17;
    logic [10:0]       x17_div8;
    logic [24:0]       div5_prod;
    logic [CHAN_W-1:0] up;
    logic [CHAN_W-1:0] down;
    always_comb begin
        x17       = {r_s1_x, 4'b0000} + 14'(r_s1_x);
        x17_div8  = x17[13:3];
        div5_prod = 25'(x17_div8) * 25'(DIV5_MUL);
        up        = div5_prod[DIV5_SH +: CHAN_W];
        down      = CHAN_W'(FULL) - up;
    end

    // Channel selection by segment
    always_comb begin
        case (r_s1_seg)
            SEG_RED_UP_G: begin
                n_red = CHAN_W'(FULL); n_green = up;   n_blue = '0;
            end
            SEG_GRN_DN_R: begin
                n_red = down; n_green = CHAN_W'(FULL); n_blue = '0;
            end
            SEG_GRN_UP_B: begin
                n_red = '0; n_green = CHAN_W'(FULL); n_blue = up;
            end
            SEG_BLU_DN_G: begin
                n_red = '0; n_green = down; n_blue = CHAN_W'(FULL);
            end
            SEG_BLU_UP_R: begin
                n_red = up; n_green = '0; n_blue = CHAN_W'(FULL);
            end
            default: begin
                n_red = CHAN_W'(FULL); n_green = '0; n_blue = down;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_phase    <= '0;
            r_led      <= '0;
            r_off      <= '0;
            r_rem      <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_take) begin
                r_busy  <= 1'b1;
                r_phase <= n_phase;
                r_led   <= '0;
                r_off   <= '0;
                r_rem   <= '0;
            end else if (r_busy && en) begin
                if (gen_last) begin
                    r_busy <= 1'b0;
                end
                r_led <= n_led;
                r_off <= n_off;
                r_rem <= n_rem;
            end
            if (en) begin
                r_s1_valid <= r_busy;
                r_o_valid  <= r_s1_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_seg  <= n_s1_seg;
            r_s1_x    <= n_s1_x;
            r_s1_led  <= r_led;
            r_s1_last <= gen_last;
            r_o_led   <= r_s1_led;
            r_o_red   <= n_red;
            r_o_green <= n_green;
            r_o_blue  <= n_blue;
            r_o_last  <= r_s1_last;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_led_index = r_o_led;
    assign o_red       = r_o_red;
    assign o_green     = r_o_green;
    assign o_blue      = r_o_blue;
    assign o_last_led  = r_o_last;

endmodule

[rtl/core/rhws_checker.sv]
`timescale 1ns / 1ps

module rhws_checker
    import rhws_pkg::*;
#(
    parameter int LED_COUNT = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                o_ready,
    input  logic [MS_W-1:0]     i_elapsed_ms,
    input  logic                o_valid,
    input  logic                i_ready,
    input  logic [LED_W-1:0]    o_led_index,
    input  logic [CHAN_W-1:0]   o_red,
    input  logic [CHAN_W-1:0]   o_green,
    input  logic [CHAN_W-1:0]   o_blue,
    input  logic                o_last_led
);

    localparam int LEDS = (LED_COUNT < 1) ? 1 :
                          ((LED_COUNT > LED_MAX) ? LED_MAX : LED_COUNT);

    // Offered tick word holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_elapsed_ms))
        else $error("tick word changed or dropped while waiting");

    // Last marker only on the final LED
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_led |-> o_led_index == LED_W'(LEDS - 1))
        else $error("last_led on wrong LED index");

    // Words of one tick come out back to back in index order
    a_next_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_led
        |=> o_valid && o_led_index == $past(o_led_index) + LED_W'(1))
        else $error("LED sequence broken inside a tick");

    // Every hue has one full channel and one dark channel
    a_hue_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red == CHAN_W'(FULL) || o_green == CHAN_W'(FULL)
                     || o_blue == CHAN_W'(FULL))
                 && (o_red == '0 || o_green == '0 || o_blue == '0))
        else $error("color word is not on the hue wheel");

    // Stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_led_index) && $stable(o_red)
                                && $stable(o_green) && $stable(o_blue)
                                && $stable(o_last_led))
        else $error("output word changed while stalled");

endmodule

bind rainbow_hue_wheel_strip_unit rhws_checker #(.LED_COUNT(LED_COUNT)) u_rhws_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_elapsed_ms (i_elapsed_ms),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_led_index  (o_led_index),
    .o_red        (o_red),
    .o_green      (o_green),
    .o_blue       (o_blue),
    .o_last_led   (o_last_led)
);
